@@ hw/rtl/lcwf_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the LED colour wheel fader.
package lcwf_pkg;

  // Strip geometry and brightness limits
  localparam int PIXEL_COUNT  = 16;
  localparam int MAX_LEVEL    = 255;
  localparam int MIN_LEVEL    = 32;
  localparam int LEVEL_STEP   = (MAX_LEVEL - MIN_LEVEL) / PIXEL_COUNT;
  localparam int BRIGHT_RESET = 128;
  localparam int WHEEL_SIZE   = 6;

  // Field widths
  localparam int LEVEL_W   = 8;
  localparam int COLOUR_W  = 24;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 3;

  // Ceiling reciprocal of the step, exact for any 8-bit dividend with a 16-bit shift
  localparam int RECIP_SHIFT = 16;
  localparam int LIT_RECIP   = (2 ** RECIP_SHIFT + LEVEL_STEP - 1) / LEVEL_STEP;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [COLOUR_W-1:0]  colour_t;
  typedef logic [CFG_IDX_W-1:0] wheel_idx_t;
  typedef logic [COUNT_W-1:0]   count_t;

  // Reset wheel: red, yellow, green, cyan, blue, magenta
  localparam colour_t WHEEL_RESET [WHEEL_SIZE] = '{
    24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'hFF00FF
  };

  // Fade stage output towards the scaling stage
  typedef struct packed {
    logic   bar;
    level_t brightness;
    level_t red;
    level_t green;
    level_t blue;
  } fade_t;

  // One unit towards the target
  function automatic level_t step_toward(level_t v, level_t t);
    if (v < t) begin
      return v + level_t'(1);
    end else if (v > t) begin
      return v - level_t'(1);
    end
    return v;
  endfunction

  // Wheel position read modulo the wheel size
  function automatic wheel_idx_t wheel_pos(wheel_idx_t idx);
    if (idx >= wheel_idx_t'(WHEEL_SIZE)) begin
      return idx - wheel_idx_t'(WHEEL_SIZE);
    end
    return idx;
  endfunction

  // Next wheel position, wrapping at the end
  function automatic wheel_idx_t wheel_next(wheel_idx_t idx);
    if (idx == wheel_idx_t'(WHEEL_SIZE - 1)) begin
      return '0;
    end
    return idx + wheel_idx_t'(1);
  endfunction

  // Exact floor(x / 255) for a product of two 8-bit values
  function automatic level_t div255(logic [2*LEVEL_W-1:0] x);
    logic [2*LEVEL_W:0] s;
    s = {1'b0, x} + (2*LEVEL_W+1)'(x[2*LEVEL_W-1:LEVEL_W]) + (2*LEVEL_W+1)'(1);
    return s[2*LEVEL_W-1:LEVEL_W];
  endfunction

  // Bar length for a brightness level, saturated at the pixel count
  function automatic count_t lit_count(level_t b);
    level_t                          off;
    logic [LEVEL_W+RECIP_SHIFT:0]    prod;
    logic [LEVEL_W:0]                cnt;
    off  = '0;
    prod = '0;
    if (b < level_t'(MIN_LEVEL)) begin
      cnt = (LEVEL_W+1)'(1);
    end else begin
      off  = b - level_t'(MIN_LEVEL);
      prod = (LEVEL_W+RECIP_SHIFT+1)'(off) * (LEVEL_W+RECIP_SHIFT+1)'(LIT_RECIP);
      cnt  = prod[LEVEL_W+RECIP_SHIFT:RECIP_SHIFT] + (LEVEL_W+1)'(1);
    end
    if (cnt > (LEVEL_W+1)'(PIXEL_COUNT)) begin
      cnt = (LEVEL_W+1)'(PIXEL_COUNT);
    end
    return cnt[COUNT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/lcwf_in_if.sv @@
`timescale 1ns / 1ps
// Tick request channel carrying the two button levels.
interface lcwf_in_if;
  logic valid;
  logic ready;
  logic up_button;
  logic down_button;

  modport source (output valid, output up_button, output down_button, input ready);
  modport sink   (input valid, input up_button, input down_button, output ready);
endinterface

@@ hw/rtl/lcwf_out_if.sv @@
`timescale 1ns / 1ps
// Result request channel carrying the pixel drive values.
interface lcwf_out_if;
  logic       valid;
  logic       ready;
  logic       bar_mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [4:0] lit_count;

  modport source (output valid, output bar_mode, output red, output green, output blue,
                  output lit_count, input ready);
  modport sink   (input valid, input bar_mode, input red, input green, input blue,
                  input lit_count, output ready);
endinterface

@@ hw/rtl/lcwf_fade.sv @@
`timescale 1ns / 1ps
// Button edge detection, brightness stepping and colour fade state.
module lcwf_fade (
  input  logic                clk,
  input  logic                rst,
  lcwf_in_if.sink             tick,
  input  lcwf_pkg::colour_t   wheel [lcwf_pkg::WHEEL_SIZE],
  output logic                s1_valid,
  output lcwf_pkg::fade_t     s1_data,
  input  logic                s1_ready
);
  import lcwf_pkg::*;

  logic       prev_up;
  logic       prev_down;
  level_t     brightness;
  level_t     cur_red;
  level_t     cur_green;
  level_t     cur_blue;
  wheel_idx_t target_index;

  logic       take;
  logic       up_rise;
  logic       down_rise;
  logic       held;
  level_t     brightness_next;
  wheel_idx_t pos;
  wheel_idx_t pos_next;
  colour_t    tgt_cur;
  colour_t    tgt;
  logic       at_target;
  level_t     red_next;
  level_t     green_next;
  level_t     blue_next;

  // Accept a request whenever the stage register is free or draining
  assign tick.ready = !s1_valid || s1_ready;
  assign take       = tick.valid && tick.ready;

  // Edges and brightness step; a raise refused at the ceiling falls back to a lower
  always_comb begin
    up_rise         = tick.up_button && !prev_up;
    down_rise       = tick.down_button && !prev_down;
    held            = tick.up_button || tick.down_button;
    brightness_next = brightness;
    if (up_rise && brightness <= level_t'(MAX_LEVEL - LEVEL_STEP)) begin
      brightness_next = brightness + level_t'(LEVEL_STEP);
    end else if (down_rise && brightness >= level_t'(MIN_LEVEL + LEVEL_STEP)) begin
      brightness_next = brightness - level_t'(LEVEL_STEP);
    end
  end

  // Target selection and one-unit fade step
  always_comb begin
    pos        = wheel_pos(target_index);
    tgt_cur    = wheel[pos];
    at_target  = {cur_red, cur_green, cur_blue} == tgt_cur;
    pos_next   = at_target ? wheel_next(pos) : pos;
    tgt        = wheel[pos_next];
    red_next   = step_toward(cur_red,   tgt[23:16]);
    green_next = step_toward(cur_green, tgt[15:8]);
    blue_next  = step_toward(cur_blue,  tgt[7:0]);
  end

  // State update on each accepted tick; fade holds while a button is down
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_up      <= 1'b0;
      prev_down    <= 1'b0;
      brightness   <= level_t'(BRIGHT_RESET);
      cur_red      <= '0;
      cur_green    <= '0;
      cur_blue     <= level_t'(MAX_LEVEL);
      target_index <= '0;
    end else if (take) begin
      prev_up    <= tick.up_button;
      prev_down  <= tick.down_button;
      brightness <= brightness_next;
      if (!held) begin
        cur_red      <= red_next;
        cur_green    <= green_next;
        cur_blue     <= blue_next;
        target_index <= pos_next;
      end
    end
  end

  // Stage register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage register payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_data.bar        <= held;
      s1_data.brightness <= brightness_next;
      s1_data.red        <= red_next;
      s1_data.green      <= green_next;
      s1_data.blue       <= blue_next;
    end
  end

endmodule

@@ hw/rtl/lcwf_scale.sv @@
`timescale 1ns / 1ps
// Brightness scaling, bar length and result register.
module lcwf_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            s1_valid,
  input  lcwf_pkg::fade_t s1_data,
  output logic            s1_ready,
  lcwf_out_if.source      result
);
  import lcwf_pkg::*;

  logic                   out_valid;
  logic                   out_bar;
  level_t                 out_red;
  level_t                 out_green;
  level_t                 out_blue;
  count_t                 out_lit;

  logic                   load;
  logic [2*LEVEL_W-1:0]   prod_red;
  logic [2*LEVEL_W-1:0]   prod_green;
  logic [2*LEVEL_W-1:0]   prod_blue;
  level_t                 red_next;
  level_t                 green_next;
  level_t                 blue_next;
  count_t                 lit_next;

  assign s1_ready = !out_valid || result.ready;
  assign load     = s1_valid && s1_ready;

  // Colour times brightness / 255, or white at the brightness level in bar mode
  always_comb begin
    prod_red   = (2*LEVEL_W)'(s1_data.red)   * (2*LEVEL_W)'(s1_data.brightness);
    prod_green = (2*LEVEL_W)'(s1_data.green) * (2*LEVEL_W)'(s1_data.brightness);
    prod_blue  = (2*LEVEL_W)'(s1_data.blue)  * (2*LEVEL_W)'(s1_data.brightness);
    if (s1_data.bar) begin
      red_next   = s1_data.brightness;
      green_next = s1_data.brightness;
      blue_next  = s1_data.brightness;
      lit_next   = lit_count(s1_data.brightness);
    end else begin
      red_next   = div255(prod_red);
      green_next = div255(prod_green);
      blue_next  = div255(prod_blue);
      lit_next   = count_t'(PIXEL_COUNT);
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_bar   <= s1_data.bar;
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
      out_lit   <= lit_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.bar_mode  = out_bar;
  assign result.red       = out_red;
  assign result.green     = out_green;
  assign result.blue      = out_blue;
  assign result.lit_count = out_lit;

endmodule

@@ hw/rtl/led_colour_wheel_fader.sv @@
`timescale 1ns / 1ps
// Top level of the LED colour wheel fader: wheel registers and the two-stage pipeline.
//
// One tick request is taken per clock when the result side is not stalled; each
// produces exactly one result. The first stage holds the button history, brightness
// and fading colour, updating history and brightness on every accepted tick and the
// colour only while no button is held; the second stage scales it by brightness / 255
// with one 8x8 product per channel, or forms the white brightness bar while a button
// is held. The user writes the six wheel colours via the cfg port while no request
// is in flight, not enforced by the block; writes to indexes above five are dropped.
module led_colour_wheel_fader (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  lcwf_pkg::wheel_idx_t       cfg_index,
  input  lcwf_pkg::colour_t          cfg_data,
  lcwf_in_if.sink                    tick,
  lcwf_out_if.source                 result
);
  import lcwf_pkg::*;

  colour_t wheel [WHEEL_SIZE];
  logic    s1_valid;
  fade_t   s1_data;
  logic    s1_ready;

  // Wheel colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel <= WHEEL_RESET;
    end else if (cfg_we && cfg_index < wheel_idx_t'(WHEEL_SIZE)) begin
      wheel[cfg_index] <= cfg_data;
    end
  end

  lcwf_fade u_fade (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .wheel    (wheel),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  lcwf_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready),
    .result   (result)
  );

`ifndef SYNTH
  // An accepted tick always lands in the first stage
  a_tick_lands: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> s1_valid)
    else $error("accepted tick not held in first stage");

  // A first-stage entry with a free or draining result register moves on next cycle
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ready) |=> result.valid)
    else $error("first stage entry lost");

  // Bar mode shows white
  a_bar_white: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.bar_mode) |->
      (result.red == result.green && result.green == result.blue))
    else $error("bar mode colour not white");

  // Fade mode lights the whole strip
  a_fade_full: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.bar_mode) |-> (result.lit_count == count_t'(PIXEL_COUNT)))
    else $error("fade mode lit count wrong");
`endif

endmodule
